/* sv/csr_pkg.sv */
// Shared types and constants for the CAN segment reassembler.
// Holds the result status codes, the frame limits and the controller/datapath structs.
// No dependencies.
package csr_pkg;

  localparam int CHANNELS_DEF  = 4;
  localparam int BUF_BYTES_DEF = 64;

  localparam int MAX_FRAME_BYTES = 8;
  localparam logic [3:0] SEQ_MASK = 4'hF;

  localparam logic [2:0] ST_PARTIAL  = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_BAD_CHAN = 3'd2;
  localparam logic [2:0] ST_SEQ_ERR  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef struct packed {
    logic latch;
    logic eval;
    logic wr_step;
    logic rd_issue;
    logic load_out;
    logic out_byte;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic seq_err;
    logic ovf;
    logic wr_done;
    logic complete;
    logic empty;
    logic emit_last;
    logic clr_done;
    logic out_free;
  } sts_t;

endpackage

/* sv/can_segment_reassembler_top.sv */
// Top level of the CAN segment reassembler.
// Depends on csr_pkg, csr_ctrl and csr_datapath (which holds csr_ram).
//
// Usage: one frame per transfer on the in_ channel; every frame yields one
// result transfer on the out_ channel, or, when it completes a message, one
// transfer per stored message byte with out_tlast on the final byte.
// Flow: an accepted frame is checked and writes its bytes (byte_count clamped
// to 8) before its result enters the output register; a rejected frame goes
// from the check to the result. A completed message then alternates a store
// read and an output load per byte, as the store has a single read port.
// One frame is in work at a time; in_tready is high only between frames.
// Reset: contexts clear at once, then the message store is cleared one byte
// a cycle over all CHANNELS*BUF_BYTES bytes, while in_tready stays low.
// Stall: a waiting result holds in the output register; the next frame is
// still taken, and work halts only when another result must be loaded.
module can_segment_reassembler_top #(
  parameter int CHANNELS  = csr_pkg::CHANNELS_DEF,
  parameter int BUF_BYTES = csr_pkg::BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // channel[3:0], seq_no[7:4], byte_count[11:8], payload[75:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // src_channel[3:0], byte_index[9:4], data_byte[17:10]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);

  csr_pkg::cmd_t cmd;
  csr_pkg::sts_t sts;

  csr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  csr_datapath #(
    .CHANNELS  (CHANNELS),
    .BUF_BYTES (BUF_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* sv/csr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module csr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/csr_ctrl.sv */
// Sequencer for the CAN segment reassembler: clear pass, frame check, byte write, emit.
// Depends on csr_pkg for the command and status structs.
module csr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  csr_pkg::sts_t sts,
  output csr_pkg::cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_PUT   = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.bad || sts.seq_err || sts.ovf) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        if (!sts.wr_done) begin
          cmd.wr_step = 1'b1;
        end else if (sts.complete && !sts.empty) begin
          state_nxt = S_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_PUT;
      end
      S_PUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_byte = 1'b1;
          state_nxt    = sts.emit_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/csr_datapath.sv */
// Datapath for the CAN segment reassembler: frame registers, channel contexts,
// message store and the output register. Depends on csr_pkg and csr_ram.
module csr_datapath #(
  parameter int CHANNELS  = csr_pkg::CHANNELS_DEF,
  parameter int BUF_BYTES = csr_pkg::BUF_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [79:0]   in_tdata,
  input  csr_pkg::cmd_t cmd,
  output csr_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [23:0]   out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);

  localparam int DEPTH = CHANNELS * BUF_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PW    = $clog2(BUF_BYTES + 1);

  logic [3:0]    ch_r, seq_r, len_r, i_r;
  logic [63:0]   pay_r;
  logic [3:0]    last_seq_r [CHANNELS];
  logic [7:0]    cnt_r      [CHANNELS];
  logic [7:0]    mlen_r     [CHANNELS];
  logic [PW-1:0] wo_r       [CHANNELS];
  logic [AW-1:0] base_r, clr_addr_r;
  logic [PW-1:0] pos_r;
  logic [7:0]    k_r, n_r;
  logic [2:0]    res_st_r;
  logic          complete_r, empty_r;

  logic          out_valid_r;
  logic [2:0]    out_st_r;
  logic [3:0]    out_ch_r;
  logic [5:0]    out_idx_r;
  logic [7:0]    out_data_r;
  logic          out_last_r;

  logic [3:0]    in_len;
  logic          bad, seq0, seq_err, ovf, pos_in;
  logic [CW-1:0] ch_idx;
  logic [3:0]    exp_seq;
  logic [7:0]    base_cnt, new_cnt, msg_len;
  logic [PW-1:0] base_off, wo_sat;
  logic [PW:0]   off_sum;
  logic [AW-1:0] chan_base;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  assign in_len   = (in_tdata[11:8] > 4'(csr_pkg::MAX_FRAME_BYTES)) ?
                    4'(csr_pkg::MAX_FRAME_BYTES) : in_tdata[11:8];
  assign bad      = {1'b0, ch_r} >= 5'(CHANNELS);
  assign ch_idx   = bad ? '0 : ch_r[CW-1:0];
  assign seq0     = (seq_r == 4'd0);
  assign exp_seq  = (last_seq_r[ch_idx] + 4'd1) & csr_pkg::SEQ_MASK;
  assign seq_err  = !seq0 && (seq_r != exp_seq);
  assign base_cnt = seq0 ? 8'd0 : cnt_r[ch_idx];
  assign new_cnt  = base_cnt + {4'd0, len_r};
  assign ovf      = new_cnt > 8'(BUF_BYTES);
  assign msg_len  = seq0 ? pay_r[7:0] : mlen_r[ch_idx];
  assign base_off = seq0 ? '0 : wo_r[ch_idx];
  assign off_sum  = {1'b0, base_off} + (PW+1)'(len_r);
  assign wo_sat   = (off_sum > (PW+1)'(BUF_BYTES)) ? PW'(BUF_BYTES) : off_sum[PW-1:0];
  assign chan_base = AW'(int'(ch_idx) * BUF_BYTES);
  assign pos_in   = pos_r < PW'(BUF_BYTES);

  assign ram_we    = cmd.clr_step || (cmd.wr_step && pos_in);
  assign ram_waddr = cmd.clr_step ? clr_addr_r : base_r + AW'(pos_r);
  assign ram_wdata = cmd.clr_step ? 8'd0 : pay_r[7:0];
  assign ram_raddr = base_r + AW'(k_r);

  csr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.bad       = bad;
    sts.seq_err   = seq_err;
    sts.ovf       = ovf;
    sts.wr_done   = (i_r == len_r);
    sts.complete  = complete_r;
    sts.empty     = empty_r;
    sts.emit_last = ((k_r + 8'd1) == n_r);
    sts.clr_done  = (clr_addr_r == AW'(DEPTH - 1));
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r  <= in_tdata[3:0];
      seq_r <= in_tdata[7:4];
      len_r <= in_len;
      pay_r <= in_tdata[75:12];
      i_r   <= 4'd0;
    end
    if (cmd.eval) begin
      base_r     <= chan_base;
      pos_r      <= base_off;
      k_r        <= 8'd0;
      n_r        <= new_cnt;
      complete_r <= (new_cnt == msg_len);
      empty_r    <= (new_cnt == 8'd0);
      if (bad) begin
        res_st_r <= csr_pkg::ST_BAD_CHAN;
      end else if (seq_err) begin
        res_st_r <= csr_pkg::ST_SEQ_ERR;
      end else if (ovf) begin
        res_st_r <= csr_pkg::ST_OVERFLOW;
      end else if (new_cnt != msg_len) begin
        res_st_r <= csr_pkg::ST_PARTIAL;
      end else begin
        res_st_r <= csr_pkg::ST_COMPLETE;
      end
    end
    if (cmd.wr_step) begin
      pay_r <= {8'd0, pay_r[63:8]};
      i_r   <= i_r + 4'd1;
      if (pos_in) begin
        pos_r <= pos_r + PW'(1);
      end
    end
    if (cmd.load_out && cmd.out_byte) begin
      k_r <= k_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_seq_r[c] <= 4'd0;
        cnt_r[c]      <= 8'd0;
        mlen_r[c]     <= 8'd0;
        wo_r[c]       <= '0;
      end
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.eval && !bad && !seq_err) begin
        cnt_r[ch_idx] <= new_cnt;
        if (seq0) begin
          mlen_r[ch_idx] <= pay_r[7:0];
        end
        if (!ovf) begin
          last_seq_r[ch_idx] <= seq_r;
          wo_r[ch_idx]       <= wo_sat;
        end else if (seq0) begin
          wo_r[ch_idx] <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ch_r <= ch_r;
      if (cmd.out_byte) begin
        out_st_r   <= csr_pkg::ST_COMPLETE;
        out_idx_r  <= k_r[5:0];
        out_data_r <= ram_rdata;
        out_last_r <= sts.emit_last;
      end else begin
        out_st_r   <= res_st_r;
        out_idx_r  <= 6'd0;
        out_data_r <= 8'd0;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {6'd0, out_data_r, out_idx_r, out_ch_r};
  assign out_tlast  = out_last_r;

  a_wr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |-> (i_r < len_r))
    else $error("byte write past frame length");

  a_emit_in_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_byte) |-> (k_r < n_r))
    else $error("emitted byte beyond message length");

  a_rd_complete: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |-> (complete_r && !empty_r && res_st_r == csr_pkg::ST_COMPLETE))
    else $error("store read without a completed message");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_step |=> (pos_r <= PW'(BUF_BYTES)))
    else $error("write offset beyond buffer");

endmodule

/* test/can_segment_reassembler_checker.sv */
`timescale 1ns / 1ps
// Result checker for the CAN segment reassembler: mirrors the per-channel contexts and
// message store, predicts the results of every frame transfer and compares them in order.
// Depends on csr_pkg.
module can_segment_reassembler_checker
  import csr_pkg::*;
#(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [2:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending_count,
  output int          frame_count,
  output int          result_count,
  output int          message_count
);

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] channel;
    logic [5:0] byte_idx;
    logic [7:0] data;
    logic       last;
  } frame_result_t;

  logic [3:0] ctx_last_seq [CHANNELS];
  logic [7:0] ctx_count    [CHANNELS];
  logic [7:0] ctx_length   [CHANNELS];
  logic [6:0] ctx_offset   [CHANNELS];
  logic [7:0] msg_store    [CHANNELS*BUF_BYTES];

  frame_result_t pending_results[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    frame_count   = 0;
    result_count  = 0;
    message_count = 0;
  end

  function automatic void clear_contexts();
    for (int c = 0; c < CHANNELS; c++) begin
      ctx_last_seq[c] = '0;
      ctx_count[c]    = '0;
      ctx_length[c]   = '0;
      ctx_offset[c]   = '0;
    end
    for (int a = 0; a < CHANNELS*BUF_BYTES; a++) msg_store[a] = '0;
    pending_results.delete();
  endfunction

  function automatic void queue_result(input logic [2:0] status, input logic [3:0] ch,
                                       input int idx, input logic [7:0] data,
                                       input logic last);
    frame_result_t r;
    r.status   = status;
    r.channel  = ch;
    r.byte_idx = 6'(idx);
    r.data     = data;
    r.last     = last;
    pending_results.push_back(r);
  endfunction

  function automatic void reassemble_frame(input logic [79:0] frame);
    logic [3:0]  ch;
    logic [3:0]  seq;
    logic [3:0]  len;
    logic [63:0] pay;
    int          base;
    int          pos;
    int          n;
    ch  = frame[3:0];
    seq = frame[7:4];
    len = frame[11:8];
    pay = frame[75:12];
    if (len > MAX_FRAME_BYTES) len = 4'(MAX_FRAME_BYTES);
    if (ch >= CHANNELS) begin
      queue_result(ST_BAD_CHAN, ch, 0, 8'h00, 1'b1);
      return;
    end
    base = ch * BUF_BYTES;
    if (seq == 4'd0) begin
      ctx_offset[ch] = '0;
      ctx_count[ch]  = '0;
      ctx_length[ch] = pay[7:0];
    end else if (seq != ((ctx_last_seq[ch] + 4'd1) & SEQ_MASK)) begin
      queue_result(ST_SEQ_ERR, ch, 0, 8'h00, 1'b1);
      return;
    end
    ctx_count[ch] = ctx_count[ch] + 8'(len);
    if (ctx_count[ch] > BUF_BYTES) begin
      queue_result(ST_OVERFLOW, ch, 0, 8'h00, 1'b1);
      return;
    end
    for (int i = 0; i < len; i++) begin
      pos = ctx_offset[ch] + i;
      if (pos < BUF_BYTES) msg_store[base + pos] = pay[8*i +: 8];
    end
    pos = ctx_offset[ch] + len;
    ctx_offset[ch] = (pos > BUF_BYTES) ? 7'(BUF_BYTES) : 7'(pos);
    ctx_last_seq[ch] = seq;
    if (ctx_count[ch] != ctx_length[ch]) begin
      queue_result(ST_PARTIAL, ch, 0, 8'h00, 1'b1);
    end else if (ctx_count[ch] == 8'd0) begin
      queue_result(ST_COMPLETE, ch, 0, 8'h00, 1'b1);
      message_count++;
    end else begin
      n = ctx_count[ch];
      for (int i = 0; i < n; i++) begin
        queue_result(ST_COMPLETE, ch, i, msg_store[base + i], i == n - 1);
      end
      message_count++;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 30) begin
      $display("%0t: result %0d %s: got %0d, expected %0d", $time, result_count, what, got,
               want);
    end
  endtask

  task automatic check_result();
    frame_result_t want;
    result_count++;
    if (pending_results.size() == 0) begin
      report_mismatch("arrived with nothing pending, status", out_tuser, 0);
      return;
    end
    want = pending_results.pop_front();
    if (out_tuser != want.status) report_mismatch("status", out_tuser, want.status);
    if (out_tdata[3:0] != want.channel) report_mismatch("channel", out_tdata[3:0], want.channel);
    if (out_tdata[9:4] != want.byte_idx) begin
      report_mismatch("byte index", out_tdata[9:4], want.byte_idx);
    end
    if (out_tdata[17:10] != want.data) report_mismatch("data byte", out_tdata[17:10], want.data);
    if (out_tlast != want.last) report_mismatch("tlast", out_tlast, want.last);
    if (out_tdata[23:18] != '0) report_mismatch("tdata padding", out_tdata[23:18], 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_contexts();
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) begin
        reassemble_frame(in_tdata);
        frame_count++;
      end
    end
    pending_count = pending_results.size();
  end

endmodule

/* test/can_segment_reassembler_top_test.sv */
`timescale 1ns / 1ps
// Testbench top for can_segment_reassembler_top: drives directed and random CAN frames,
// stalls the result channel, and reports the verdict from can_segment_reassembler_checker.
// Depends on csr_pkg, the reassembler RTL and can_segment_reassembler_checker.
module can_segment_reassembler_top_test;

  localparam int RANDOM_ITEMS = 180;
  localparam int CALM_AFTER   = 145;
  localparam int WRAP_AT      = 60;
  localparam int LONG_HOLD    = 300;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;

  typedef enum int {GEN_MESSAGE, GEN_RAW, GEN_NOISE, GEN_OVERFLOW} frame_gen_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int pending_count;
  int frame_count;
  int result_count;
  int message_count;
  int items_sent   = 0;
  int quiet_cycles = 0;
  bit idle_on      = 1'b1;
  bit stall_on     = 1'b1;
  bit hold_req     = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  can_segment_reassembler_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  can_segment_reassembler_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .frame_count   (frame_count),
    .result_count  (result_count),
    .message_count (message_count)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("can_segment_reassembler_top test failed");
      $finish;
    end
  end

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_frame(input logic [3:0] ch, input logic [3:0] seq,
                            input logic [3:0] cnt, input logic [63:0] pay);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, pay, cnt, seq, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic send_noise(input logic [3:0] ch, input logic [3:0] next_seq);
    logic [3:0] seq;
    if ($urandom_range(0, 1) == 0) begin
      send_frame(4'($urandom_range(csr_pkg::CHANNELS_DEF, 15)), 4'($urandom),
                 4'($urandom_range(0, 15)), rand_payload());
    end else begin
      do seq = 4'($urandom_range(1, 15)); while (seq == next_seq);
      send_frame(ch, seq, 4'($urandom_range(0, 15)), rand_payload());
    end
  endtask

  // split the message into frames; messages over 32 bytes use at least 4 bytes per frame
  // so their sequence never runs past 15 (one of 17 to 32 bytes may still run past it)
  task automatic send_message(input logic [3:0] ch, input int total);
    int         sent;
    int         n;
    int         lo;
    logic [3:0] seq;
    logic [3:0] cnt;
    logic [63:0] pay;
    sent = 0;
    seq  = 4'd0;
    lo   = (total > 32) ? 4 : 1;
    do begin
      n = $urandom_range(lo, 8);
      if (n > total - sent) n = total - sent;
      cnt = 4'(n);
      if (n == 8 && $urandom_range(0, 3) == 0) cnt = 4'($urandom_range(9, 15));
      pay = rand_payload();
      if (seq == 4'd0) pay[7:0] = 8'(total);
      if ($urandom_range(0, 7) == 0) send_noise(ch, seq);
      send_frame(ch, seq, cnt, pay);
      sent += n;
      seq++;
    end while (sent < total);
  endtask

  task automatic fill_buffer(input logic [3:0] ch, input logic [7:0] length);
    logic [63:0] pay;
    pay      = rand_payload();
    pay[7:0] = length;
    send_frame(ch, 4'd0, 4'd8, pay);
    for (int s = 1; s < 8; s++) send_frame(ch, 4'(s), 4'($urandom_range(8, 15)), rand_payload());
  endtask

  task automatic send_overflow(input logic [3:0] ch);
    fill_buffer(ch, 8'($urandom_range(65, 255)));
    repeat ($urandom_range(1, 3)) send_frame(ch, 4'd8, 4'd8, rand_payload());
  endtask

  // overflow until the count wraps to zero, then complete on the wrapped count
  task automatic send_count_wrap(input logic [3:0] ch);
    fill_buffer(ch, 8'd4);
    repeat (24) send_frame(ch, 4'd8, 4'($urandom_range(8, 15)), rand_payload());
    send_frame(ch, 4'd9, 4'd4, rand_payload());
  endtask

  initial begin
    int          rand_start;
    int          r;
    bit          wrap_done;
    frame_gen_e  gen;
    logic [63:0] pay;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_frame(4'hF, 4'hF, 4'hF, '1);
    send_frame(4'(csr_pkg::CHANNELS_DEF), 4'd1, 4'd3, rand_payload());
    send_frame(4'd0, 4'd5, 4'd8, '0);
    send_frame(4'd0, 4'd0, 4'd0, '0);
    send_frame(4'd1, 4'd0, 4'd0, 64'h3);
    send_frame(4'd1, 4'd1, 4'd3, 64'hA5C30F);
    send_frame(4'd2, 4'd0, 4'd8, {56'hFF_FFFF_FFFF_FFFF, 8'd8});
    pay      = rand_payload();
    pay[7:0] = 8'd16;
    send_frame(4'd3, 4'd0, 4'hF, pay);
    send_frame(4'd3, 4'd1, 4'd9, rand_payload());
    for (int i = 0; i < 16; i++) begin
      pay = rand_payload();
      if (i == 0) pay[7:0] = 8'd64;
      send_frame(4'd0, 4'(i), 4'd4, pay);
    end

    rand_start = items_sent;
    wrap_done  = 1'b0;
    hold_req   = 1'b1;
    while (items_sent < rand_start + RANDOM_ITEMS) begin
      if (items_sent >= rand_start + CALM_AFTER) begin
        idle_on  = 1'b0;
        stall_on = 1'b0;
      end
      if (!wrap_done && items_sent >= rand_start + WRAP_AT) begin
        send_count_wrap(4'($urandom_range(0, csr_pkg::CHANNELS_DEF - 1)));
        wrap_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        gen = (r < 60) ? GEN_MESSAGE : (r < 78) ? GEN_RAW : (r < 90) ? GEN_NOISE : GEN_OVERFLOW;
        case (gen)
          GEN_MESSAGE: begin
            send_message(4'($urandom_range(0, csr_pkg::CHANNELS_DEF - 1)),
                         ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                                     : $urandom_range(1, 16));
          end
          GEN_RAW: begin
            send_frame(4'($urandom), 4'($urandom), 4'($urandom), rand_payload());
          end
          GEN_NOISE: begin
            send_noise(4'($urandom_range(0, csr_pkg::CHANNELS_DEF - 1)),
                       4'($urandom_range(1, 15)));
          end
          default: begin
            send_overflow(4'($urandom_range(0, csr_pkg::CHANNELS_DEF - 1)));
          end
        endcase
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d frames and %0d result transfers, with %0d completed messages.",
             frame_count, result_count, message_count);
    $display("Included bad channels, sequence errors, overflows, a count wrap and a long stall.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("can_segment_reassembler_top test passed");
    end else begin
      $display("can_segment_reassembler_top test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/csr_pkg.sv
sv/csr_ram.sv
sv/csr_ctrl.sv
sv/csr_datapath.sv
sv/can_segment_reassembler_top.sv
test/can_segment_reassembler_checker.sv
test/can_segment_reassembler_top_test.sv
